FILE: rtl/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte deque package
// Widths, codes and the result record shared by the deque modules.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH    = 64;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int MODE_W   = 2;
	localparam int LEN_W    = 7;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 7;

	// Output buffer between the store and the result channel.
	localparam int FIFO_DEPTH = 3;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_PUSH_HEAD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_TAIL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_POP_HEAD  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_POP_TAIL  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_BYTE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PUSH_OK  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PUSH_REJ = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic [STATUS_W-1:0] status;
		logic                end_of_run;
		logic [FILL_W-1:0]   fill_level;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/bdq_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte deque command channel
// Valid/ready channel carrying one push byte or one pop request per transaction.
// ----------------------------------------------------------------------------
interface bdq_cmd_if import bdq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [LEN_W-1:0]  req_length;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, output mode, output req_length, output data_byte,
		output last_byte, input ready);
	modport sink (input valid, input mode, input req_length, input data_byte,
		input last_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/bdq_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte deque result channel
// Valid/ready channel carrying one popped byte or one status per transaction.
// ----------------------------------------------------------------------------
interface bdq_res_if import bdq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   out_byte;
	logic [STATUS_W-1:0] status;
	logic                end_of_run;
	logic [FILL_W-1:0]   fill_level;

	modport source (output valid, output out_byte, output status, output end_of_run,
		output fill_level, input ready);
	modport sink (input valid, input out_byte, input status, input end_of_run,
		input fill_level, output ready);
endinterface
`default_nettype wire

FILE: rtl/bdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte deque controller
// Holds the byte store, the head/tail indices and the fill count, writes
// pushed bytes and walks the store one byte per cycle on a pop unless stalled.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	bdq_cmd_if.sink                    cmd,
	input  wire logic [FIFO_CNT_W-1:0] level,
	output logic                       res_valid,
	output res_t                       res_data
);

	localparam int SUM_W = IDX_W + 2;
	localparam int SPC_W = FIFO_CNT_W + 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_PUSH = 3'b010,
		S_POP  = 3'b100
	} state_t;

	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
		input logic [FILL_W-1:0] amt);
		logic [SUM_W-1:0] sum;
		begin
			sum = SUM_W'(idx) + SUM_W'(amt);
			if (sum >= SUM_W'(DEPTH)) begin
				sum = sum - SUM_W'(DEPTH);
			end
			return sum[IDX_W-1:0];
		end
	endfunction

	function automatic logic [IDX_W-1:0] wrap_sub(input logic [IDX_W-1:0] idx,
		input logic [FILL_W-1:0] amt);
		logic [SUM_W-1:0] sum;
		begin
			sum = SUM_W'(idx) + SUM_W'(DEPTH) - SUM_W'(amt);
			if (sum >= SUM_W'(DEPTH)) begin
				sum = sum - SUM_W'(DEPTH);
			end
			return sum[IDX_W-1:0];
		end
	endfunction

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
		begin
			return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
		end
	endfunction

	logic [BYTE_W-1:0] mem [DEPTH];

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  head_q, head_d, tail_q, tail_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic              acc_q, acc_d;
	logic [IDX_W-1:0]  ptr_q, ptr_d;
	logic [LEN_W-1:0]  rem_q, rem_d;
	logic [IDX_W-1:0]  pop_addr_q, pop_addr_d;
	logic [FILL_W-1:0] pop_left_q, pop_left_d;
	logic [FILL_W-1:0] pop_fill_q, pop_fill_d;

	logic              s1_valid_s1, s1_valid_d;
	res_t              res_s1, res_d;
	logic [BYTE_W-1:0] rd_data_s1;

	logic              space_ok, accept, fits, rd_en, wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [FILL_W-1:0] pop_n;

	// A new result may be launched only if the buffer can still hold it
	// once the one already in flight has landed.
	assign space_ok  = (SPC_W'(level) + SPC_W'(s1_valid_s1)) < SPC_W'(FIFO_DEPTH);
	assign cmd.ready = space_ok && (state_q != S_POP);
	assign accept    = cmd.valid && cmd.ready;
	assign fits      = ((FILL_W + 1)'(fill_q) + (FILL_W + 1)'(cmd.req_length))
		<= (FILL_W + 1)'(DEPTH);
	assign pop_n     = (fill_q < cmd.req_length) ? fill_q : cmd.req_length;

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		fill_d     = fill_q;
		acc_d      = acc_q;
		ptr_d      = ptr_q;
		rem_d      = rem_q;
		pop_addr_d = pop_addr_q;
		pop_left_d = pop_left_q;
		pop_fill_d = pop_fill_q;
		s1_valid_d = 1'b0;
		res_d      = '0;
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = ptr_q;
		unique case (state_q)
			S_IDLE, S_PUSH: begin
				if (accept) begin
					if (state_q == S_IDLE && cmd.mode[1]) begin
						if (pop_n == '0) begin
							s1_valid_d       = 1'b1;
							res_d.status     = ST_EMPTY;
							res_d.end_of_run = 1'b1;
							res_d.fill_level = fill_q;
						end else begin
							if (cmd.mode == MODE_POP_HEAD) begin
								pop_addr_d = head_q;
								head_d     = wrap_add(head_q, pop_n);
							end else begin
								tail_d     = wrap_sub(tail_q, pop_n);
								pop_addr_d = tail_d;
							end
							fill_d     = fill_q - pop_n;
							pop_left_d = pop_n;
							pop_fill_d = fill_q;
							state_d    = S_POP;
						end
					end else begin
						// The first transaction of a push reserves the space.
						if (state_q == S_IDLE) begin
							acc_d = fits;
							rem_d = '0;
							if (fits) begin
								if (cmd.mode == MODE_PUSH_HEAD) begin
									head_d = wrap_sub(head_q, cmd.req_length);
									ptr_d  = head_d;
								end else begin
									ptr_d  = tail_q;
									tail_d = wrap_add(tail_q, cmd.req_length);
								end
								fill_d = fill_q + cmd.req_length;
								rem_d  = cmd.req_length;
							end
						end
						if (acc_d && rem_d != '0) begin
							wr_en   = 1'b1;
							wr_addr = ptr_d;
							ptr_d   = wrap_inc(ptr_d);
							rem_d   = rem_d - 1'b1;
						end
						if (cmd.last_byte) begin
							s1_valid_d       = 1'b1;
							res_d.status     = acc_d ? ST_PUSH_OK : ST_PUSH_REJ;
							res_d.end_of_run = 1'b1;
							res_d.fill_level = fill_d;
							rem_d            = '0;
							state_d          = S_IDLE;
						end else begin
							state_d = S_PUSH;
						end
					end
				end
			end
			S_POP: begin
				if (space_ok) begin
					rd_en            = 1'b1;
					s1_valid_d       = 1'b1;
					res_d.status     = ST_BYTE;
					res_d.end_of_run = (pop_left_q == FILL_W'(1));
					res_d.fill_level = pop_fill_q - 1'b1;
					pop_fill_d       = pop_fill_q - 1'b1;
					pop_left_d       = pop_left_q - 1'b1;
					pop_addr_d       = wrap_inc(pop_addr_q);
					if (pop_left_q == FILL_W'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			acc_q       <= 1'b0;
			ptr_q       <= '0;
			rem_q       <= '0;
			pop_addr_q  <= '0;
			pop_left_q  <= '0;
			pop_fill_q  <= '0;
			s1_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			fill_q      <= fill_d;
			acc_q       <= acc_d;
			ptr_q       <= ptr_d;
			rem_q       <= rem_d;
			pop_addr_q  <= pop_addr_d;
			pop_left_q  <= pop_left_d;
			pop_fill_q  <= pop_fill_d;
			s1_valid_s1 <= s1_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= res_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd.data_byte;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[pop_addr_q];
		end
	end

	always_comb begin
		res_data = res_s1;
		res_data.out_byte = (res_s1.status == ST_BYTE) ? rd_data_s1 : '0;
	end
	assign res_valid = s1_valid_s1;

endmodule
`default_nettype wire

FILE: rtl/bdq_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte deque result buffer
// Small register FIFO that holds results while the receiver stalls.
// ----------------------------------------------------------------------------
module bdq_out_fifo import bdq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_valid,
	input  wire res_t                  wr_data,
	output logic [FIFO_CNT_W-1:0]      level,
	bdq_res_if.source                  result
);

	res_t                  slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  deq;
	res_t                  head;

	function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
		begin
			return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
		end
	endfunction

	assign head              = slot_q[rd_ptr_q];
	assign result.valid      = (count_q != '0);
	assign result.out_byte   = head.out_byte;
	assign result.status     = head.status;
	assign result.end_of_run = head.end_of_run;
	assign result.fill_level = head.fill_level;
	assign deq               = result.valid && result.ready;
	assign level             = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (deq) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + FIFO_CNT_W'(wr_valid) - FIFO_CNT_W'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/byte_deque_ring_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte deque ring buffer
// A deque of up to DEPTH bytes kept in a circular store.
//
// The cmd channel takes one transaction per pushed byte; the first byte of a
// push carries the total length, and the push is taken whole or dropped whole.
// A pop is one transaction asking for up to req_length bytes from the head or
// the tail. The result channel gives one status after the last byte of a push,
// one transaction per popped byte, or one empty status.
// Pushes run at one byte per cycle while the result buffer has room. A push
// status passes the result register and then that buffer. A pop holds cmd
// until its last byte is read; its bytes pass the read register and buffer
// at one byte a cycle while there is room, paced by the single read port.
// Reset empties the deque at once; no clearing pass is needed. When the
// receiver stalls, a three-entry result buffer fills and then cmd.ready and
// the pop walk stop until room is made.
// ----------------------------------------------------------------------------
module byte_deque_ring_buffer import bdq_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bdq_cmd_if.sink    cmd,
	bdq_res_if.source  result
);

	logic                  res_valid;
	res_t                  res_data;
	logic [FIFO_CNT_W-1:0] level;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.level     (level),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	bdq_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (res_valid),
		.wr_data  (res_data),
		.level    (level),
		.result   (result)
	);

	// A full buffer must never be written unless a transaction leaves in the same cycle.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && level == FIFO_CNT_W'(FIFO_DEPTH)) |-> result.ready)
		else $error("result buffer overflow");

	// With the buffer full no new command may be taken.
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(level == FIFO_CNT_W'(FIFO_DEPTH)) |-> !cmd.ready)
		else $error("command taken while result buffer full");

	// Reported fill never exceeds the store size.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.fill_level <= FILL_W'(DEPTH)))
		else $error("fill level beyond depth");

endmodule
`default_nettype wire

FILE: test/bdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte deque result checker
// Watches both channels of the deque, keeps its own copy of the ring store and
// its pointers, works out the results of each command transaction and compares
// every result transaction, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module bdq_checker import bdq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	bdq_cmd_if        cmd,
	bdq_res_if        result,
	output int        fail_count,
	output int        pending
);

	logic [BYTE_W-1:0] store_bytes [DEPTH];
	int   head_at;
	int   tail_at;
	int   held;
	logic in_push;
	logic push_ok;
	int   write_at;
	int   bytes_left;
	res_t owed_results [$];

	task automatic absorb_command(input logic [MODE_W-1:0] op, input logic [LEN_W-1:0] len,
		input logic [BYTE_W-1:0] data, input logic last);
		int   want;
		int   take;
		int   at;
		res_t r;
		want = int'(len);
		if (!in_push && (op == MODE_POP_HEAD || op == MODE_POP_TAIL)) begin
			take = (held < want) ? held : want;
			if (take == 0) begin
				r.out_byte   = '0;
				r.status     = ST_EMPTY;
				r.end_of_run = 1'b1;
				r.fill_level = FILL_W'(held);
				owed_results.push_back(r);
			end else begin
				if (op == MODE_POP_HEAD) begin
					at      = head_at;
					head_at = (head_at + take) % DEPTH;
				end else begin
					tail_at = (tail_at + DEPTH - take) % DEPTH;
					at      = tail_at;
				end
				// Bytes leave in storage order whichever end they come from.
				for (int i = 0; i < take; i++) begin
					held         = held - 1;
					r.out_byte   = store_bytes[(at + i) % DEPTH];
					r.status     = ST_BYTE;
					r.end_of_run = (i == take - 1);
					r.fill_level = FILL_W'(held);
					owed_results.push_back(r);
				end
			end
		end else begin
			// The first byte reserves the whole string or nothing at all.
			if (!in_push) begin
				in_push = 1'b1;
				if (held + want <= DEPTH) begin
					push_ok = 1'b1;
					if (op == MODE_PUSH_HEAD) begin
						head_at  = (head_at + DEPTH - want) % DEPTH;
						write_at = head_at;
					end else begin
						write_at = tail_at;
						tail_at  = (tail_at + want) % DEPTH;
					end
					held       = held + want;
					bytes_left = want;
				end else begin
					push_ok    = 1'b0;
					bytes_left = 0;
				end
			end
			if (push_ok && bytes_left > 0) begin
				store_bytes[write_at] = data;
				write_at              = (write_at + 1) % DEPTH;
				bytes_left            = bytes_left - 1;
			end
			if (last) begin
				in_push      = 1'b0;
				bytes_left   = 0;
				r.out_byte   = '0;
				r.status     = push_ok ? ST_PUSH_OK : ST_PUSH_REJ;
				r.end_of_run = 1'b1;
				r.fill_level = FILL_W'(held);
				owed_results.push_back(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want_res;
		if (!arst_n) begin
			// The store is undefined after reset; zeros stand in until written.
			for (int i = 0; i < DEPTH; i++) store_bytes[i] = '0;
			head_at    = 0;
			tail_at    = 0;
			held       = 0;
			in_push    = 1'b0;
			push_ok    = 1'b0;
			write_at   = 0;
			bytes_left = 0;
			owed_results.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cmd.valid && cmd.ready)
				absorb_command(cmd.mode, cmd.req_length, cmd.data_byte, cmd.last_byte);
			if (result.valid && result.ready) begin
				got.out_byte   = result.out_byte;
				got.status     = result.status;
				got.end_of_run = result.end_of_run;
				got.fill_level = result.fill_level;
				if (owed_results.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result with nothing owed: byte %h status %0d end %b fill %0d",
							$realtime, got.out_byte, got.status, got.end_of_run,
							got.fill_level);
					fail_count++;
				end else begin
					want_res = owed_results.pop_front();
					if (got.out_byte !== want_res.out_byte || got.status !== want_res.status ||
						got.end_of_run !== want_res.end_of_run ||
						got.fill_level !== want_res.fill_level) begin
						if (fail_count < 10)
							$display({"%0t: mismatch: expected byte %h status %0d end %b ",
								"fill %0d, got byte %h status %0d end %b fill %0d"},
								$realtime, want_res.out_byte, want_res.status,
								want_res.end_of_run, want_res.fill_level, got.out_byte,
								got.status, got.end_of_run, got.fill_level);
						fail_count++;
					end
				end
			end
			pending = owed_results.size();
		end
	end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte deque ring buffer testbench
// Drives push strings and pop requests into the deque: a directed opening on
// the corner cases, then random well-formed and broken strings over phases of
// sender gaps and receiver stalls. The checker beside the block gives the
// failure count; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import bdq_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 10;
	localparam int ITEMS_PER_STEP = 70;
	localparam int STALL_LIMIT    = 5000;
	localparam int SETTLE_CYCLES  = 10;
	localparam int SEND_IDLE [4]  = '{0, 74, 0, 32};
	localparam int RECV_STALL [4] = '{0, 0, 74, 32};

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   items_sent;
	int   quiet_cycles;
	int   fail_count;
	int   pending;

	bdq_cmd_if cmd ();
	bdq_res_if result ();

	byte_deque_ring_buffer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.result (result)
	);

	bdq_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #HALF_PERIOD clk = ~clk;

	// Ends the run when neither channel completes a transaction for too long.
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (result.valid && result.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles == STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			result.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Entered and left at a falling edge; valid stays high into a following call.
	task automatic send_item(input logic [MODE_W-1:0] op, input logic [LEN_W-1:0] len,
		input logic [BYTE_W-1:0] data, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(negedge clk);
		end
		cmd.valid      <= 1'b1;
		cmd.mode       <= op;
		cmd.req_length <= len;
		cmd.data_byte  <= data;
		cmd.last_byte  <= last;
		do @(posedge clk); while (!cmd.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// A string of byte_count transactions declaring len bytes; later bytes carry
	// random mode and length, which the block must ignore mid-string.
	task automatic push_string(input logic [MODE_W-1:0] op, input int len,
		input int byte_count, input logic [BYTE_W-1:0] first_data);
		send_item(op, LEN_W'(len), first_data, byte_count == 1);
		for (int k = 1; k < byte_count; k++)
			send_item(MODE_W'($urandom_range(3)), LEN_W'($urandom_range(127)),
				BYTE_W'($urandom), k == byte_count - 1);
	endtask

	task automatic drain;
		cmd.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic random_command;
		int pick;
		int len;
		int byte_count;
		logic [MODE_W-1:0] op;
		pick = $urandom_range(99);
		op   = $urandom_range(1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD;
		if (pick < 45) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(1, 10);
			push_string(op, len, (len == 0) ? 1 : len, BYTE_W'($urandom));
		end else if (pick < 57) begin
			case ($urandom_range(2))
				0: begin
					len        = $urandom_range(2, 12);
					byte_count = $urandom_range(1, len - 1);
				end
				1: begin
					len        = $urandom_range(8);
					byte_count = len + $urandom_range(1, 3);
				end
				default: begin
					len        = $urandom_range(65, 127);
					byte_count = $urandom_range(1, 4);
				end
			endcase
			push_string(op, len, byte_count, BYTE_W'($urandom));
		end else begin
			op = $urandom_range(1) ? MODE_POP_TAIL : MODE_POP_HEAD;
			case ($urandom_range(9))
				0:       len = 0;
				1:       len = $urandom_range(13, 127);
				default: len = $urandom_range(1, 12);
			endcase
			send_item(op, LEN_W'(len), BYTE_W'($urandom), $urandom_range(1));
		end
	endtask

	initial begin
		int step_start;
		arst_n         = 1'b0;
		quiet_cycles   = 0;
		items_sent     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		cmd.valid      = 1'b0;
		cmd.mode       = MODE_PUSH_HEAD;
		cmd.req_length = '0;
		cmd.data_byte  = '0;
		cmd.last_byte  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A full-length string first, so that every slot of the store holds a
		// written byte before any short string leaves holes.
		push_string(MODE_PUSH_HEAD, DEPTH, DEPTH, 8'h00);
		push_string(MODE_PUSH_TAIL, 1, 1, 8'hFF);
		send_item(MODE_POP_HEAD, 7'd3, 8'hFF, 1'b1);
		send_item(MODE_POP_TAIL, 7'd127, 8'h00, 1'b0);
		send_item(MODE_POP_HEAD, 7'd5, 8'h5A, 1'b0);
		push_string(MODE_PUSH_HEAD, 0, 1, 8'hFF);
		push_string(MODE_PUSH_TAIL, 3, 3, 8'hFF);
		push_string(MODE_PUSH_HEAD, 2, 3, 8'h00);
		push_string(MODE_PUSH_TAIL, 4, 2, 8'hA5);
		send_item(MODE_POP_TAIL, 7'd0, 8'h00, 1'b0);
		push_string(MODE_PUSH_TAIL, 100, 2, 8'h3C);
		push_string(MODE_PUSH_HEAD, 65, 1, 8'hC3);
		send_item(MODE_POP_TAIL, 7'd2, 8'h00, 1'b0);
		send_item(MODE_POP_HEAD, 7'd64, 8'hFF, 1'b1);
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = SEND_IDLE[p];
			recv_stall_pct = RECV_STALL[p];
			step_start     = items_sent;
			while (items_sent - step_start < ITEMS_PER_STEP) random_command();
			drain();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
